// ----- src/sdcpwm_pkg.sv -----
// Shared types and constants for the serial decimal command PWM block.
// No dependencies; used by every module in src.
package sdcpwm_pkg;

  localparam int unsigned ACC_W   = 17;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MULT_W  = 20;

  localparam logic [ACC_W-1:0]  ACC_SAT    = 17'd65536;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 16'd65535;
  localparam logic [DUTY_W-1:0] STEP_RESET = 16'd25033;

  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_LO_O  = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_UP_O  = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] BEAT_LAST = 2'd3;

  typedef enum logic [1:0] {
    RC_PIN = 2'd0,
    RC_DOT = 2'd1,
    RC_OK  = 2'd2
  } reply_code_t;

  typedef struct packed {
    logic        has_result;
    reply_code_t code;
    logic        pin;
  } reply_t;

endpackage

// ----- src/serial_decimal_command_dithered_pwm.sv -----
// Serial decimal command parser with dithered PWM output. Top level.
// A request reaches the input register at acceptance; when it advances, its result
// is loaded into the result register, which presents it on the output.
// Throughput: one tick per cycle while each result is taken at once; an 'a'/'o' command
// holds the result register for four output beats, '.' for one. Digits produce no result
// and never wait in the input register.
// Reset (rst, synchronous): accumulator, duty, phase cleared; phase_step = 25033.
module serial_decimal_command_dithered_pwm import sdcpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DUTY_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [BYTE_W-1:0] tx_byte,
  output logic              pin_level,
  output logic              last
);

  logic              in_v;
  logic              in_op;
  logic [BYTE_W-1:0] in_byte;
  logic [DUTY_W-1:0] phase_step;
  reply_t            reply;
  logic              em_free;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_v && (!reply.has_result || em_free);
  assign in_ready  = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v       <= 1'b0;
      phase_step <= STEP_RESET;
    end else begin
      if (in_valid && in_ready) begin
        in_v <= 1'b1;
      end else if (advance) begin
        in_v <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        phase_step <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op   <= operation;
      in_byte <= rx_byte;
    end
  end

  sdcpwm_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .operation  (in_op),
    .rx_byte    (in_byte),
    .phase_step (phase_step),
    .reply      (reply)
  );

  sdcpwm_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && reply.has_result),
    .reply     (reply),
    .free      (em_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .pin_level (pin_level),
    .last      (last)
  );

  // a tick always ends its own reply in one beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last && (tx_byte == CH_NUL))
    else $error("pin result not a single beat");

  // a held request with a result never advances while the result register is busy
  assert property (@(posedge clk) disable iff (rst)
    advance && reply.has_result |-> em_free)
    else $error("result register overwritten");

  // an accepted request is held in the input register next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> in_v)
    else $error("accepted request lost");

  // an unfinished multi-beat reply keeps the output valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && !kind)
    else $error("reply burst cut short");

endmodule

// ----- src/sdcpwm_parser.sv -----
// Command parser and PWM state: accumulator, duty value, phase counter.
// Depends on sdcpwm_pkg.
module sdcpwm_parser import sdcpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              operation,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [DUTY_W-1:0] phase_step,
  output reply_t            reply
);

  logic [ACC_W-1:0]  acc, acc_next;
  logic [DUTY_W-1:0] duty, duty_next;
  logic [DUTY_W-1:0] phase, phase_next;
  logic [MULT_W-1:0] acc_x10;
  logic [DUTY_W:0]   wrap_sum;
  logic              is_digit, is_a, is_o;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_a     = (rx_byte == CH_LO_A) || (rx_byte == CH_UP_A);
  assign is_o     = (rx_byte == CH_LO_O) || (rx_byte == CH_UP_O);

  // times ten as two shifts, plus the digit
  assign acc_x10 = ({3'b000, acc} << 3) + ({3'b000, acc} << 1)
                 + MULT_W'(rx_byte - CH_ZERO);
  // 65535 - step is ~step; modulo 65535 wrap when counter < step
  assign wrap_sum = {1'b0, phase} + {1'b0, ~phase_step};

  always_comb begin
    acc_next   = acc;
    duty_next  = duty;
    phase_next = phase;
    reply      = '{has_result: 1'b1, code: RC_DOT, pin: 1'b0};
    if (operation == OP_TICK) begin
      reply.code = RC_PIN;
      reply.pin  = (phase < duty);
      if (phase >= phase_step) begin
        phase_next = phase - phase_step;
      end else begin
        phase_next = wrap_sum[DUTY_W-1:0];
      end
    end else if (is_digit) begin
      reply.has_result = 1'b0;
      acc_next = (acc_x10 > MULT_W'(ACC_SAT)) ? ACC_SAT : acc_x10[ACC_W-1:0];
    end else if (is_a) begin
      reply.code = RC_OK;
      duty_next  = (acc > ACC_W'(DUTY_MAX)) ? DUTY_MAX : acc[DUTY_W-1:0];
      acc_next   = '0;
    end else if (is_o) begin
      reply.code = RC_OK;
      duty_next  = '0;
      acc_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      duty  <= '0;
      phase <= '0;
    end else if (fire) begin
      acc   <= acc_next;
      duty  <= duty_next;
      phase <= phase_next;
    end
  end

endmodule

// ----- src/sdcpwm_emitter.sv -----
// Result register and reply sequencer: one beat for pin or '.', four for "ok\r\n".
// Depends on sdcpwm_pkg.
module sdcpwm_emitter import sdcpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  reply_t            reply,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [BYTE_W-1:0] tx_byte,
  output logic              pin_level,
  output logic              last
);

  logic        res_valid;
  reply_code_t code;
  logic        pin;
  logic [1:0]  beat;
  logic        done;

  assign out_valid = res_valid;
  assign done      = res_valid && out_ready && last;
  assign free      = !res_valid || done;

  always_comb begin
    kind      = 1'b0;
    tx_byte   = CH_NUL;
    pin_level = 1'b0;
    last      = 1'b1;
    unique case (code)
      RC_PIN: begin
        kind      = 1'b1;
        pin_level = pin;
      end
      RC_DOT: tx_byte = CH_DOT;
      RC_OK: begin
        last = (beat == BEAT_LAST);
        unique case (beat)
          2'd0:    tx_byte = CH_LO_O;
          2'd1:    tx_byte = CH_K;
          2'd2:    tx_byte = CH_CR;
          default: tx_byte = CH_LF;
        endcase
      end
      default: tx_byte = CH_DOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      beat      <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      beat      <= '0;
    end else if (done) begin
      res_valid <= 1'b0;
    end else if (res_valid && out_ready) begin
      beat <= beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code <= reply.code;
      pin  <= reply.pin;
    end
  end

endmodule
